// ===== hdl/spq_pkg.sv =====
// Shared types, sizes and helpers for the strict priority packet queue.
// No dependencies; every other file of the block except spq_ram refers to this package.
package spq_pkg;

  // Queue sizing
  localparam int CLASS_DEPTH = 64;
  localparam int SLOT_DEPTH  = 64;
  localparam int PTR_W       = $clog2(CLASS_DEPTH);
  localparam int CNT_W       = $clog2(CLASS_DEPTH + 1);
  localparam int SLOT_W      = $clog2(SLOT_DEPTH + 1);
  localparam int MEM_DEPTH   = 2 * CLASS_DEPTH;
  localparam int ADDR_W      = $clog2(MEM_DEPTH);

  // Field widths
  localparam int SIZE_W     = 12;
  localparam int TAG_W      = 16;
  localparam int BYTES_W    = 20;
  localparam int DESC_W     = TAG_W + SIZE_W;
  localparam int ACC_W      = SIZE_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [BYTES_W-1:0] BYTES_MAX     = {BYTES_W{1'b1}};
  localparam logic [SIZE_W-1:0]  CFG_RST_SIZE  = 12'd1500;
  localparam logic [ACC_W-1:0]   QUANTUM_ZERO  = 13'd4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PUSH_QUANTUM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUMMY_SLOT_SIZE = 2'd1;

  // Packet kind boundaries
  localparam logic [3:0] KIND_LO_LAST = 4'd3;
  localparam logic [3:0] KIND_HDR     = 4'd4;
  localparam logic [3:0] KIND_HI_LAST = 4'd11;
  localparam logic [3:0] KIND_RLB     = 4'd12;

  typedef enum logic [1:0] {
    REQ_ENQ      = 2'd0,
    REQ_SVC      = 2'd1,
    REQ_DOORBELL = 2'd2,
    REQ_UNUSED   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    CLS_RLB  = 2'd0,
    CLS_LO   = 2'd1,
    CLS_HI   = 2'd2,
    CLS_NONE = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_UNKNOWN = 2'd1,
    STS_FULL    = 2'd2,
    STS_NO_SLOT = 2'd3
  } status_t;

  // Remainder unit handshake
  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [ACC_W-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] remainder;
  } rem_rsp_t;

  // Saturating byte-total add
  function automatic logic [BYTES_W-1:0] bytes_add(input logic [BYTES_W-1:0] a,
                                                   input logic [BYTES_W-1:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[BYTES_W] ? BYTES_MAX : s[BYTES_W-1:0];
  endfunction

endpackage

// ===== hdl/spq_ifs.sv =====
// Channel interfaces of the strict priority packet queue: request, result
// and configuration write. Depends on spq_pkg for field widths.
interface spq_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 req_type;
  logic [3:0]                 pkt_kind;
  logic                       header_only;
  logic [spq_pkg::SIZE_W-1:0] pkt_size;
  logic [spq_pkg::TAG_W-1:0]  pkt_tag;
  logic                       rlb_waiting;

  modport source (output valid, req_type, pkt_kind, header_only, pkt_size, pkt_tag,
                  rlb_waiting, input ready);
  modport sink   (input valid, req_type, pkt_kind, header_only, pkt_size, pkt_tag,
                  rlb_waiting, output ready);
endinterface

interface spq_out_if;
  logic                        valid;
  logic                        ready;
  logic                        sent_valid;
  logic [spq_pkg::TAG_W-1:0]   sent_tag;
  logic [spq_pkg::SIZE_W-1:0]  sent_size;
  logic                        sent_class;
  logic                        rlb_pull;
  logic                        rlb_push;
  logic [1:0]                  serving_class;
  logic [spq_pkg::BYTES_W-1:0] total_bytes;
  logic [1:0]                  status;

  modport source (output valid, sent_valid, sent_tag, sent_size, sent_class, rlb_pull,
                  rlb_push, serving_class, total_bytes, status, input ready);
  modport sink   (input valid, sent_valid, sent_tag, sent_size, sent_class, rlb_pull,
                  rlb_push, serving_class, total_bytes, status, output ready);
endinterface

interface spq_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [spq_pkg::CFG_IDX_W-1:0]  index;
  logic [spq_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/spq_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/spq_rem.sv =====
// Iterative remainder unit: restoring division, one quotient bit a cycle.
// Depends on spq_pkg for widths and the request/response structs.
module spq_rem (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::rem_req_t req,
  output spq_pkg::rem_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(spq_pkg::ACC_W + 1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_BITS-1:0]         cnt_r, cnt_nxt;
  logic [spq_pkg::ACC_W-1:0]   dvd_r, dvd_nxt;
  logic [spq_pkg::ACC_W-1:0]   dvs_r, dvs_nxt;
  logic [spq_pkg::SIZE_W-1:0]  rem_r, rem_nxt;
  logic [spq_pkg::ACC_W-1:0]   trial;

  // Shift in one dividend bit and subtract the divisor when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[spq_pkg::ACC_W-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_BITS'(spq_pkg::ACC_W);
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = (trial >= dvs_r) ? spq_pkg::SIZE_W'(trial - dvs_r)
                                 : spq_pkg::SIZE_W'(trial);
      dvd_nxt = {dvd_r[spq_pkg::ACC_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== hdl/strict_priority_packet_queue_unit.sv =====
// Top level of the strict priority packet queue scheduler.
// Depends on spq_pkg, spq_ifs (channels), spq_ram and spq_rem.
//
// Usage:
//   in_chan  carries one request beat: enqueue, service complete or doorbell.
//   out_chan returns exactly one result beat per request, in order.
//   cfg_chan writes push_quantum (index 0) or dummy_slot_size (index 1);
//   other indexes are ignored. Write it only while the block is idle.
// Sequencing:
//   One request at a time. Enqueue, doorbell and idle service pass from
//   accept to result beat through decode, reselect and output load. A send
//   of a high or low packet adds the descriptor RAM read; when the push
//   remainder plus the sent size reaches twice the push quantum, the
//   remainder unit adds its bitwise pass over the 13-bit accumulator.
//   in_chan.ready rises again the cycle after the result is loaded.
// Reset:
//   rst_n (synchronous, active low) clears counts, heads, byte totals and
//   the push remainder, sets the served class to none and both registers
//   to 1500. Descriptor RAM contents are left as they are.
// Stall:
//   The result register holds its beat until out_chan.ready; a next request
//   is accepted meanwhile and waits at its output step.
module strict_priority_packet_queue_unit (
  input  logic  clk,
  input  logic  rst_n,
  spq_in_if.sink    in_chan,
  spq_out_if.source out_chan,
  spq_cfg_if.sink   cfg_chan
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_READ, S_DIV, S_SEL, S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Latched request
  logic [1:0]                  req_r, req_nxt;
  logic [3:0]                  kind_r, kind_nxt;
  logic                        hdr_r, hdr_nxt;
  logic [spq_pkg::SIZE_W-1:0]  size_r, size_nxt;
  logic [spq_pkg::TAG_W-1:0]   tag_r, tag_nxt;
  logic                        wait_r, wait_nxt;

  // Configuration
  logic [spq_pkg::SIZE_W-1:0]  quantum_r, quantum_nxt;
  logic [spq_pkg::SIZE_W-1:0]  dummy_r, dummy_nxt;

  // Queue state
  logic [spq_pkg::PTR_W-1:0]   head_r [2];
  logic [spq_pkg::PTR_W-1:0]   head_nxt [2];
  logic [spq_pkg::CNT_W-1:0]   count_r [2];
  logic [spq_pkg::CNT_W-1:0]   count_nxt [2];
  logic [spq_pkg::BYTES_W-1:0] bytes_rlb_r, bytes_rlb_nxt;
  logic [spq_pkg::BYTES_W-1:0] bytes_lo_r, bytes_lo_nxt;
  logic [spq_pkg::BYTES_W-1:0] bytes_hi_r, bytes_hi_nxt;
  logic [spq_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [1:0]                  serving_r, serving_nxt;
  logic [spq_pkg::SIZE_W-1:0]  push_rem_r, push_rem_nxt;

  // Per-item flags
  logic                        q_r, q_nxt;
  logic                        sel_r, sel_nxt;
  logic                        s_valid_r, s_valid_nxt;
  logic [spq_pkg::TAG_W-1:0]   s_tag_r, s_tag_nxt;
  logic [spq_pkg::SIZE_W-1:0]  s_size_r, s_size_nxt;
  logic                        pull_r, pull_nxt;
  logic                        push_r, push_nxt;
  logic [1:0]                  status_r, status_nxt;

  // Result register
  logic                        out_valid_r, out_valid_nxt;
  logic                        o_sent_valid_r, o_sent_valid_nxt;
  logic [spq_pkg::TAG_W-1:0]   o_tag_r, o_tag_nxt;
  logic [spq_pkg::SIZE_W-1:0]  o_size_r, o_size_nxt;
  logic                        o_class_r, o_class_nxt;
  logic                        o_pull_r, o_pull_nxt;
  logic                        o_push_r, o_push_nxt;
  logic [1:0]                  o_serving_r, o_serving_nxt;
  logic [spq_pkg::BYTES_W-1:0] o_total_r, o_total_nxt;
  logic [1:0]                  o_status_r, o_status_nxt;

  // RAM and remainder unit
  logic                        ram_we, ram_re;
  logic [spq_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [spq_pkg::DESC_W-1:0]  ram_wdata, ram_rdata;
  spq_pkg::rem_req_t           rem_req;
  spq_pkg::rem_rsp_t           rem_rsp;

  // Combinational helpers
  logic                        in_acc, cfg_acc;
  logic                        kind_lo, kind_hi, kind_rlb;
  logic                        idx;
  logic                        was_empty;
  logic [spq_pkg::PTR_W:0]     pos_sum;
  logic [spq_pkg::PTR_W-1:0]   pos;
  logic [spq_pkg::SIZE_W-1:0]  rlb_size;
  logic [spq_pkg::SIZE_W-1:0]  d_size;
  logic [spq_pkg::ACC_W-1:0]   quantum;
  logic [spq_pkg::ACC_W-1:0]   acc;
  logic [spq_pkg::ACC_W-1:0]   acc_diff;
  logic [spq_pkg::BYTES_W-1:0] cls_bytes;
  logic [spq_pkg::BYTES_W-1:0] total;

  spq_ram #(
    .WIDTH (spq_pkg::DESC_W),
    .DEPTH (spq_pkg::MEM_DEPTH)
  ) u_desc_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spq_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .rsp   (rem_rsp)
  );

  // Pick the highest eligible class
  function automatic logic [1:0] pick_class(input logic [spq_pkg::CNT_W-1:0] cnt_lo,
                                            input logic [spq_pkg::CNT_W-1:0] cnt_hi,
                                            input logic [spq_pkg::BYTES_W-1:0] b_rlb,
                                            input logic [spq_pkg::SLOT_W-1:0] slots);
    logic [1:0] c;
    if (cnt_hi != '0) begin
      c = spq_pkg::CLS_HI;
    end else if (cnt_lo != '0) begin
      c = spq_pkg::CLS_LO;
    end else if (b_rlb != '0 && slots != '0) begin
      c = spq_pkg::CLS_RLB;
    end else begin
      c = spq_pkg::CLS_NONE;
    end
    return c;
  endfunction

  assign in_acc         = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign cfg_acc        = cfg_chan.valid;

  // Kind decode
  assign kind_lo  = (kind_r <= spq_pkg::KIND_LO_LAST) || (kind_r == spq_pkg::KIND_HDR && !hdr_r);
  assign kind_hi  = (kind_r == spq_pkg::KIND_HDR && hdr_r) ||
                    (kind_r > spq_pkg::KIND_HDR && kind_r <= spq_pkg::KIND_HI_LAST);
  assign kind_rlb = (kind_r == spq_pkg::KIND_RLB);

  // Class index for this cycle: enqueue target, served class, or held index
  always_comb begin
    if (state_r == S_READ) begin
      idx = q_r;
    end else if (req_r == spq_pkg::REQ_ENQ) begin
      idx = kind_hi;
    end else begin
      idx = (serving_r == spq_pkg::CLS_HI);
    end
  end

  assign was_empty = (bytes_rlb_r == '0 && bytes_lo_r == '0 && bytes_hi_r == '0) ||
                     (serving_r == spq_pkg::CLS_NONE);

  // Tail position with wrap
  assign pos_sum = (spq_pkg::PTR_W+1)'(head_r[idx]) + (spq_pkg::PTR_W+1)'(count_r[idx]);
  assign pos     = (pos_sum >= (spq_pkg::PTR_W+1)'(spq_pkg::CLASS_DEPTH))
                 ? spq_pkg::PTR_W'(pos_sum - (spq_pkg::PTR_W+1)'(spq_pkg::CLASS_DEPTH))
                 : spq_pkg::PTR_W'(pos_sum);

  assign rlb_size  = (req_r == spq_pkg::REQ_ENQ) ? size_r : dummy_r;
  assign d_size    = ram_rdata[spq_pkg::SIZE_W-1:0];
  assign quantum   = (quantum_r == '0) ? spq_pkg::QUANTUM_ZERO : {1'b0, quantum_r};
  assign acc       = {1'b0, push_rem_r} + {1'b0, d_size};
  assign acc_diff  = acc - quantum;
  assign cls_bytes = q_r ? bytes_hi_r : bytes_lo_r;
  assign total     = spq_pkg::bytes_add(spq_pkg::bytes_add(bytes_rlb_r, bytes_lo_r),
                                        bytes_hi_r);

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    kind_nxt       = kind_r;
    hdr_nxt        = hdr_r;
    size_nxt       = size_r;
    tag_nxt        = tag_r;
    wait_nxt       = wait_r;
    quantum_nxt    = quantum_r;
    dummy_nxt      = dummy_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    bytes_rlb_nxt  = bytes_rlb_r;
    bytes_lo_nxt   = bytes_lo_r;
    bytes_hi_nxt   = bytes_hi_r;
    slot_nxt       = slot_r;
    serving_nxt    = serving_r;
    push_rem_nxt   = push_rem_r;
    q_nxt          = q_r;
    sel_nxt        = sel_r;
    s_valid_nxt    = s_valid_r;
    s_tag_nxt      = s_tag_r;
    s_size_nxt     = s_size_r;
    pull_nxt       = pull_r;
    push_nxt       = push_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    o_sent_valid_nxt = o_sent_valid_r;
    o_tag_nxt      = o_tag_r;
    o_size_nxt     = o_size_r;
    o_class_nxt    = o_class_r;
    o_pull_nxt     = o_pull_r;
    o_push_nxt     = o_push_r;
    o_serving_nxt  = o_serving_r;
    o_total_nxt    = o_total_r;
    o_status_nxt   = o_status_r;
    ram_we         = 1'b0;
    ram_waddr      = idx ? spq_pkg::ADDR_W'(spq_pkg::CLASS_DEPTH) + spq_pkg::ADDR_W'(pos)
                         : spq_pkg::ADDR_W'(pos);
    ram_wdata      = {tag_r, size_r};
    ram_re         = 1'b0;
    ram_raddr      = idx ? spq_pkg::ADDR_W'(spq_pkg::CLASS_DEPTH) + spq_pkg::ADDR_W'(head_r[idx])
                         : spq_pkg::ADDR_W'(head_r[idx]);
    rem_req.start    = 1'b0;
    rem_req.dividend = acc;
    rem_req.divisor  = quantum;

    // Register writes
    if (cfg_acc) begin
      if (cfg_chan.index == spq_pkg::CFG_PUSH_QUANTUM) begin
        quantum_nxt = cfg_chan.data;
      end else if (cfg_chan.index == spq_pkg::CFG_DUMMY_SLOT_SIZE) begin
        dummy_nxt = cfg_chan.data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt   = in_chan.req_type;
          kind_nxt  = in_chan.pkt_kind;
          hdr_nxt   = in_chan.header_only;
          size_nxt  = in_chan.pkt_size;
          tag_nxt   = in_chan.pkt_tag;
          wait_nxt  = in_chan.rlb_waiting;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        sel_nxt     = 1'b0;
        s_valid_nxt = 1'b0;
        s_tag_nxt   = '0;
        s_size_nxt  = '0;
        pull_nxt    = 1'b0;
        push_nxt    = 1'b0;
        status_nxt  = spq_pkg::STS_OK;
        q_nxt       = idx;
        state_nxt   = S_SEL;
        case (req_r)
          spq_pkg::REQ_ENQ, spq_pkg::REQ_DOORBELL: begin
            if ((req_r == spq_pkg::REQ_ENQ && kind_rlb) ||
                (req_r == spq_pkg::REQ_DOORBELL && wait_r)) begin
              // Admit a balancer slot
              if (slot_r == spq_pkg::SLOT_W'(spq_pkg::SLOT_DEPTH)) begin
                status_nxt = spq_pkg::STS_FULL;
              end else begin
                slot_nxt      = slot_r + 1'b1;
                bytes_rlb_nxt = spq_pkg::bytes_add(bytes_rlb_r,
                                                   spq_pkg::BYTES_W'(rlb_size));
                sel_nxt       = was_empty;
              end
            end else if (req_r == spq_pkg::REQ_DOORBELL) begin
              // Remove a slot
              if (slot_r == '0) begin
                status_nxt = spq_pkg::STS_NO_SLOT;
              end else begin
                slot_nxt      = slot_r - 1'b1;
                bytes_rlb_nxt = '0;
              end
            end else if (kind_lo || kind_hi) begin
              // Append a descriptor
              if (count_r[idx] == spq_pkg::CNT_W'(spq_pkg::CLASS_DEPTH)) begin
                status_nxt = spq_pkg::STS_FULL;
              end else begin
                ram_we         = 1'b1;
                count_nxt[idx] = count_r[idx] + 1'b1;
                if (idx) begin
                  bytes_hi_nxt = spq_pkg::bytes_add(bytes_hi_r, spq_pkg::BYTES_W'(size_r));
                end else begin
                  bytes_lo_nxt = spq_pkg::bytes_add(bytes_lo_r, spq_pkg::BYTES_W'(size_r));
                end
                sel_nxt = was_empty;
              end
            end else begin
              status_nxt = spq_pkg::STS_UNKNOWN;
            end
          end
          spq_pkg::REQ_SVC: begin
            sel_nxt = 1'b1;
            if (serving_r == spq_pkg::CLS_RLB) begin
              pull_nxt = (slot_r != '0);
            end else if ((serving_r == spq_pkg::CLS_LO || serving_r == spq_pkg::CLS_HI) &&
                         count_r[idx] != '0) begin
              ram_re    = 1'b1;
              state_nxt = S_READ;
            end
          end
          default: begin
          end
        endcase
      end

      S_READ: begin
        // Pop the head descriptor and account its bytes
        s_valid_nxt  = 1'b1;
        s_tag_nxt    = ram_rdata[spq_pkg::DESC_W-1:spq_pkg::SIZE_W];
        s_size_nxt   = d_size;
        head_nxt[q_r]  = (head_r[q_r] == spq_pkg::PTR_W'(spq_pkg::CLASS_DEPTH - 1))
                       ? '0 : head_r[q_r] + 1'b1;
        count_nxt[q_r] = count_r[q_r] - 1'b1;
        if (q_r) begin
          bytes_hi_nxt = (cls_bytes > spq_pkg::BYTES_W'(d_size))
                       ? cls_bytes - spq_pkg::BYTES_W'(d_size) : '0;
        end else begin
          bytes_lo_nxt = (cls_bytes > spq_pkg::BYTES_W'(d_size))
                       ? cls_bytes - spq_pkg::BYTES_W'(d_size) : '0;
        end
        push_nxt  = (acc >= quantum);
        state_nxt = S_SEL;
        if (acc < quantum) begin
          push_rem_nxt = spq_pkg::SIZE_W'(acc);
        end else if (acc_diff < quantum) begin
          push_rem_nxt = spq_pkg::SIZE_W'(acc_diff);
        end else begin
          rem_req.start = 1'b1;
          state_nxt     = S_DIV;
        end
      end

      S_DIV: begin
        if (rem_rsp.done) begin
          push_rem_nxt = rem_rsp.remainder;
          state_nxt    = S_SEL;
        end
      end

      S_SEL: begin
        if (sel_r) begin
          serving_nxt = pick_class(count_r[0], count_r[1], bytes_rlb_r, slot_r);
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        // Load the result beat once the output slot is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt    = 1'b1;
          o_sent_valid_nxt = s_valid_r;
          o_tag_nxt        = s_tag_r;
          o_size_nxt       = s_size_r;
          o_class_nxt      = s_valid_r && q_r;
          o_pull_nxt       = pull_r;
          o_push_nxt       = push_r;
          o_serving_nxt    = serving_r;
          o_total_nxt      = total;
          o_status_nxt     = status_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      quantum_r   <= spq_pkg::CFG_RST_SIZE;
      dummy_r     <= spq_pkg::CFG_RST_SIZE;
      head_r      <= '{default: '0};
      count_r     <= '{default: '0};
      bytes_rlb_r <= '0;
      bytes_lo_r  <= '0;
      bytes_hi_r  <= '0;
      slot_r      <= '0;
      serving_r   <= spq_pkg::CLS_NONE;
      push_rem_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      quantum_r   <= quantum_nxt;
      dummy_r     <= dummy_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      bytes_rlb_r <= bytes_rlb_nxt;
      bytes_lo_r  <= bytes_lo_nxt;
      bytes_hi_r  <= bytes_hi_nxt;
      slot_r      <= slot_nxt;
      serving_r   <= serving_nxt;
      push_rem_r  <= push_rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r          <= req_nxt;
    kind_r         <= kind_nxt;
    hdr_r          <= hdr_nxt;
    size_r         <= size_nxt;
    tag_r          <= tag_nxt;
    wait_r         <= wait_nxt;
    q_r            <= q_nxt;
    sel_r          <= sel_nxt;
    s_valid_r      <= s_valid_nxt;
    s_tag_r        <= s_tag_nxt;
    s_size_r       <= s_size_nxt;
    pull_r         <= pull_nxt;
    push_r         <= push_nxt;
    status_r       <= status_nxt;
    o_sent_valid_r <= o_sent_valid_nxt;
    o_tag_r        <= o_tag_nxt;
    o_size_r       <= o_size_nxt;
    o_class_r      <= o_class_nxt;
    o_pull_r       <= o_pull_nxt;
    o_push_r       <= o_push_nxt;
    o_serving_r    <= o_serving_nxt;
    o_total_r      <= o_total_nxt;
    o_status_r     <= o_status_nxt;
  end

  // Drive the result channel
  assign out_chan.valid         = out_valid_r;
  assign out_chan.sent_valid    = o_sent_valid_r;
  assign out_chan.sent_tag      = o_tag_r;
  assign out_chan.sent_size     = o_size_r;
  assign out_chan.sent_class    = o_class_r;
  assign out_chan.rlb_pull      = o_pull_r;
  assign out_chan.rlb_push      = o_push_r;
  assign out_chan.serving_class = o_serving_r;
  assign out_chan.total_bytes   = o_total_r;
  assign out_chan.status        = o_status_r;

endmodule
